// ===== hdl/sgi_pkg.sv =====
package sgi_pkg;

  // quotient bits produced by the divider chain, one per cell
  localparam int QUO_BITS = 32;

  // tolerance register
  localparam int TOL_BITS = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;
  localparam logic [1:0] REG_TOLERANCE_ADDR = 2'd0;

  // opcodes
  localparam logic [1:0] OP_LINE_LINE = 2'd0;
  localparam logic [1:0] OP_LINE_SEG  = 2'd1;
  localparam logic [1:0] OP_SEG_SEG   = 2'd2;

  // saturation limits
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // per-item control flags that travel with the divider chain
  typedef struct packed {
    logic [1:0] op;
    logic       par;
    logic       negx;
    logic       negy;
    logic       bigx;
    logic       bigy;
  } sgi_ctl_t;

  // finished result
  typedef struct packed {
    logic               hit;
    logic               parallel;
    logic               clipped;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } sgi_res_t;

endpackage

// ===== hdl/sgi_if.sv =====
interface sgi_req_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic signed [COORD_BITS-1:0] first_x1;
  logic signed [COORD_BITS-1:0] first_y1;
  logic signed [COORD_BITS-1:0] first_x2;
  logic signed [COORD_BITS-1:0] first_y2;
  logic signed [COORD_BITS-1:0] second_x1;
  logic signed [COORD_BITS-1:0] second_y1;
  logic signed [COORD_BITS-1:0] second_x2;
  logic signed [COORD_BITS-1:0] second_y2;

  modport source (
    output valid, opcode, first_x1, first_y1, first_x2, first_y2,
           second_x1, second_y1, second_x2, second_y2,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_x1, first_y1, first_x2, first_y2,
           second_x1, second_y1, second_x2, second_y2,
    output ready
  );
endinterface

interface sgi_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               parallel;
  logic               clipped;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_y;

  modport source (
    output valid, hit, parallel, clipped, cross_x, cross_y,
    input  ready
  );
  modport sink (
    input  valid, hit, parallel, clipped, cross_x, cross_y,
    output ready
  );
endinterface

// ===== hdl/sgi_front.sv =====
module sgi_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int WD         = 2*COORD_BITS+3,
  parameter int SIDE_W     = 8*COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  sgi_req_if.sink                req,
  output logic                   valid,
  output sgi_pkg::sgi_ctl_t      ctl,
  output logic [SIDE_W-1:0]      side,
  output logic [WD-1:0]          dmag,
  output logic [WD-1:0]          rem_x,
  output logic [31:0]            lo_x,
  output logic [WD-1:0]          rem_y,
  output logic [31:0]            lo_y
);
  import sgi_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int WA   = C + 1;
  localparam int WC   = 2*C + 1;
  localparam int WDS  = 2*C + 3;
  localparam int WNS  = 3*C + 3;
  localparam int WN   = WNS + FRAC_BITS;
  localparam int NPW  = (WN > WD + QUO_BITS) ? WN : WD + QUO_BITS;

  // stage A: line coefficients and boxes
  logic                 va;
  logic signed [WA-1:0] a1, b1, a2, b2;
  logic signed [WC-1:0] c1, c2;
  logic [1:0]           op_a;
  logic [SIDE_W-1:0]    box_a;

  logic signed [2*C-1:0] p1, q1, p2, q2;
  logic signed [C-1:0]   pxmin, pxmax, pymin, pymax, qxmin, qxmax, qymin, qymax;

  assign req.ready = en;

  assign p1 = req.first_x1 * req.first_y2;
  assign q1 = req.first_x2 * req.first_y1;
  assign p2 = req.second_x1 * req.second_y2;
  assign q2 = req.second_x2 * req.second_y1;

  // bounding boxes of both segments
  always_comb begin
    pxmin = (req.first_x1 < req.first_x2) ? req.first_x1 : req.first_x2;
    pxmax = (req.first_x1 < req.first_x2) ? req.first_x2 : req.first_x1;
    pymin = (req.first_y1 < req.first_y2) ? req.first_y1 : req.first_y2;
    pymax = (req.first_y1 < req.first_y2) ? req.first_y2 : req.first_y1;
    qxmin = (req.second_x1 < req.second_x2) ? req.second_x1 : req.second_x2;
    qxmax = (req.second_x1 < req.second_x2) ? req.second_x2 : req.second_x1;
    qymin = (req.second_y1 < req.second_y2) ? req.second_y1 : req.second_y2;
    qymax = (req.second_y1 < req.second_y2) ? req.second_y2 : req.second_y1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= WA'(req.first_y1) - WA'(req.first_y2);
      b1    <= WA'(req.first_x2) - WA'(req.first_x1);
      a2    <= WA'(req.second_y1) - WA'(req.second_y2);
      b2    <= WA'(req.second_x2) - WA'(req.second_x1);
      c1    <= WC'(p1) - WC'(q1);
      c2    <= WC'(p2) - WC'(q2);
      op_a  <= req.opcode;
      box_a <= {pxmin, pxmax, pymin, pymax, qxmin, qxmax, qymin, qymax};
    end
  end

  // stage B: determinant and numerators
  logic                  vb;
  logic signed [WDS-1:0] d;
  logic signed [WNS-1:0] nx, ny;
  logic [1:0]            op_b;
  logic [SIDE_W-1:0]     box_b;

  logic signed [2*C+1:0] da, db;
  logic signed [WNS-2:0] xa, xb, ya, yb;

  assign da = a1 * b2;
  assign db = a2 * b1;
  assign xa = c2 * b1;
  assign xb = c1 * b2;
  assign ya = a2 * c1;
  assign yb = a1 * c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d     <= WDS'(da) - WDS'(db);
      nx    <= WNS'(xa) - WNS'(xb);
      ny    <= WNS'(ya) - WNS'(yb);
      op_b  <= op_a;
      box_b <= box_a;
    end
  end

  // stage C: signs, magnitudes, overflow check, divider seed
  logic [WD-1:0]  dm;
  logic [WNS-1:0] nmx, nmy;
  logic [NPW-1:0] npx, npy;
  logic           bx, by;

  always_comb begin
    dm  = d[WDS-1] ? WD'(-d) : WD'(d);
    nmx = nx[WNS-1] ? WNS'(-nx) : WNS'(nx);
    nmy = ny[WNS-1] ? WNS'(-ny) : WNS'(ny);
    npx = NPW'({nmx, {FRAC_BITS{1'b0}}});
    npy = NPW'({nmy, {FRAC_BITS{1'b0}}});
    bx  = npx[NPW-1:QUO_BITS] >= (NPW-QUO_BITS)'(dm);
    by  = npy[NPW-1:QUO_BITS] >= (NPW-QUO_BITS)'(dm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.op   <= op_b;
      ctl.par  <= (d == '0);
      ctl.negx <= nx[WNS-1] ^ d[WDS-1];
      ctl.negy <= ny[WNS-1] ^ d[WDS-1];
      ctl.bigx <= bx;
      ctl.bigy <= by;
      side     <= box_b;
      dmag     <= dm;
      rem_x    <= npx[WD+QUO_BITS-1:QUO_BITS];
      lo_x     <= npx[QUO_BITS-1:0];
      rem_y    <= npy[WD+QUO_BITS-1:QUO_BITS];
      lo_y     <= npy[QUO_BITS-1:0];
    end
  end

endmodule

// ===== hdl/sgi_div_cell.sv =====
module sgi_div_cell #(
  parameter int WD     = 35,
  parameter int SIDE_W = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   prev_valid,
  input  sgi_pkg::sgi_ctl_t      prev_ctl,
  input  logic [SIDE_W-1:0]      prev_side,
  input  logic [WD-1:0]          prev_dmag,
  input  logic [WD-1:0]          prev_rem_x,
  input  logic [31:0]            prev_lo_x,
  input  logic [WD-1:0]          prev_rem_y,
  input  logic [31:0]            prev_lo_y,
  output logic                   valid,
  output sgi_pkg::sgi_ctl_t      ctl,
  output logic [SIDE_W-1:0]      side,
  output logic [WD-1:0]          dmag,
  output logic [WD-1:0]          rem_x,
  output logic [31:0]            lo_x,
  output logic [WD-1:0]          rem_y,
  output logic [31:0]            lo_y
);
  import sgi_pkg::*;

  logic [WD:0]   tx, ty, dd;
  logic          qx, qy;
  logic [WD-1:0] rx_next, ry_next;

  // one restoring step per coordinate: shift in the next dividend bit, try subtract
  always_comb begin
    dd      = {1'b0, prev_dmag};
    tx      = {prev_rem_x, prev_lo_x[31]};
    ty      = {prev_rem_y, prev_lo_y[31]};
    qx      = (tx >= dd);
    qy      = (ty >= dd);
    rx_next = qx ? WD'(tx - dd) : WD'(tx);
    ry_next = qy ? WD'(ty - dd) : WD'(ty);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  // hand the partial remainder and quotient to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      ctl   <= prev_ctl;
      side  <= prev_side;
      dmag  <= prev_dmag;
      rem_x <= rx_next;
      lo_x  <= {prev_lo_x[30:0], qx};
      rem_y <= ry_next;
      lo_y  <= {prev_lo_y[30:0], qy};
    end
  end

endmodule

// ===== hdl/sgi_back.sv =====
module sgi_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int SIDE_W     = 8*COORD_BITS
) (
  input  sgi_pkg::sgi_ctl_t           ctl,
  input  logic [SIDE_W-1:0]           side,
  input  logic [31:0]                 quo_x,
  input  logic [31:0]                 quo_y,
  input  logic [sgi_pkg::TOL_BITS-1:0] tol,
  output sgi_pkg::sgi_res_t           res
);
  import sgi_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int BW = (C + FRAC_BITS + 2 > 34) ? C + FRAC_BITS + 2 : 34;

  logic               clx, cly;
  logic signed [31:0] vx, vy;
  logic signed [BW-1:0] ex, ey, tl;
  logic signed [BW-1:0] lo [8];
  logic                 inb [4];
  logic                 box_q, box_p;

  // sign, saturate
  always_comb begin
    if (ctl.negx) begin
      clx = ctl.bigx || (quo_x[31] && (quo_x[30:0] != '0));
      vx  = clx ? Q_MIN : -$signed(quo_x);
    end else begin
      clx = ctl.bigx || quo_x[31];
      vx  = clx ? Q_MAX : $signed(quo_x);
    end
    if (ctl.negy) begin
      cly = ctl.bigy || (quo_y[31] && (quo_y[30:0] != '0));
      vy  = cly ? Q_MIN : -$signed(quo_y);
    end else begin
      cly = ctl.bigy || quo_y[31];
      vy  = cly ? Q_MAX : $signed(quo_y);
    end
  end

  // scaled box bounds widened by the tolerance; side holds min/max pairs
  always_comb begin
    ex = BW'(vx);
    ey = BW'(vy);
    tl = BW'(tol);
    for (int k = 0; k < 8; k++) begin
      lo[k] = BW'($signed(side[(7-k)*C +: C])) <<< FRAC_BITS;
    end
    // pairs: first x, first y, second x, second y
    inb[0] = (ex >= lo[0] - tl) && (ex <= lo[1] + tl);
    inb[1] = (ey >= lo[2] - tl) && (ey <= lo[3] + tl);
    inb[2] = (ex >= lo[4] - tl) && (ex <= lo[5] + tl);
    inb[3] = (ey >= lo[6] - tl) && (ey <= lo[7] + tl);
    box_p  = inb[0] && inb[1];
    box_q  = inb[2] && inb[3];
  end

  // zero everything on a parallel pair
  always_comb begin
    if (ctl.par) begin
      res = '0;
      res.parallel = 1'b1;
    end else begin
      res.parallel = 1'b0;
      res.clipped  = clx || cly;
      res.cross_x  = vx;
      res.cross_y  = vy;
      res.hit      = ((ctl.op == OP_LINE_LINE) || box_q) && (!ctl.op[1] || box_p);
    end
  end

endmodule

// ===== hdl/segment_intersection_unit.sv =====
// Segment intersection unit: takes one segment pair per clock and returns the
// crossing in signed Q16.16 with hit, parallel and clip flags, one result per
// request, in order. The pipeline has three front stages (coefficients,
// determinant and numerators, divider seed), a chain of 32 divider cells that
// each produce one quotient bit for both coordinates, and the output register.
// The whole pipeline holds while a result waits at the output, so the rate is
// one request per cycle whenever the result side takes one per cycle. The
// tolerance register sits at address 0 of the APB port and resets to 1.
module segment_intersection_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  sgi_req_if.sink     req,
  sgi_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sgi_pkg::*;

  localparam int WD     = 2*COORD_BITS + 3;
  localparam int SIDE_W = 8*COORD_BITS;

  logic                en;
  logic [TOL_BITS-1:0] tol;

  // configuration register
  assign pready = 1'b1;
  assign prdata = 32'(tol);

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_TOLERANCE_ADDR)) begin
      tol <= pwdata[TOL_BITS-1:0];
    end
  end

  // advance everything unless a result is held
  assign en = !res.valid || res.ready;

  logic              cv   [QUO_BITS+1];
  sgi_ctl_t          cc   [QUO_BITS+1];
  logic [SIDE_W-1:0] cs   [QUO_BITS+1];
  logic [WD-1:0]     cd   [QUO_BITS+1];
  logic [WD-1:0]     crx  [QUO_BITS+1];
  logic [31:0]       clx  [QUO_BITS+1];
  logic [WD-1:0]     cry  [QUO_BITS+1];
  logic [31:0]       cly  [QUO_BITS+1];

  sgi_front #(
    .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .WD(WD), .SIDE_W(SIDE_W)
  ) u_front (
    .clk(clk), .rst(rst), .en(en), .req(req),
    .valid(cv[0]), .ctl(cc[0]), .side(cs[0]), .dmag(cd[0]),
    .rem_x(crx[0]), .lo_x(clx[0]), .rem_y(cry[0]), .lo_y(cly[0])
  );

  // divider chain
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    sgi_div_cell #(.WD(WD), .SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .prev_valid(cv[i]), .prev_ctl(cc[i]), .prev_side(cs[i]), .prev_dmag(cd[i]),
      .prev_rem_x(crx[i]), .prev_lo_x(clx[i]), .prev_rem_y(cry[i]), .prev_lo_y(cly[i]),
      .valid(cv[i+1]), .ctl(cc[i+1]), .side(cs[i+1]), .dmag(cd[i+1]),
      .rem_x(crx[i+1]), .lo_x(clx[i+1]), .rem_y(cry[i+1]), .lo_y(cly[i+1])
    );
  end

  sgi_res_t fin;

  sgi_back #(
    .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)
  ) u_back (
    .ctl(cc[QUO_BITS]), .side(cs[QUO_BITS]),
    .quo_x(clx[QUO_BITS]), .quo_y(cly[QUO_BITS]), .tol(tol), .res(fin)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= cv[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit      <= fin.hit;
      res.parallel <= fin.parallel;
      res.clipped  <= fin.clipped;
      res.cross_x  <= fin.cross_x;
      res.cross_y  <= fin.cross_y;
    end
  end

  // a parallel result carries nothing else
  a_par_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.parallel |->
      res.cross_x == 0 && res.cross_y == 0 && !res.hit && !res.clipped)
    else $error("parallel result with nonzero payload");

  // a clipped result shows a saturated coordinate
  a_clip_sat: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.clipped |->
      res.cross_x == Q_MAX || res.cross_x == Q_MIN ||
      res.cross_y == Q_MAX || res.cross_y == Q_MIN)
    else $error("clip flag without saturated coordinate");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> res.valid && !res.ready)
    else $error("input stalled with no held result");

endmodule
